// File: hdl/point_cull_depth_sorter_assert.svh
// Assertion macros used by the point cull / depth sort sequencer (pcds_ctrl).
`ifndef POINT_CULL_DEPTH_SORTER_ASSERT_SVH
`define POINT_CULL_DEPTH_SORTER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PCDS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PCDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/pcds_pkg.sv
// Shared types, constants and helpers for the point cull / depth sort block.
package pcds_pkg;

    localparam int MAX_POINTS_DEF = 4096;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int COEF_W    = 32;
    localparam int OUT_IDX_W = 12;
    localparam int OUT_CNT_W = 13;

    // word kinds on the input stream
    localparam logic [1:0] KIND_COEF  = 2'd0;
    localparam logic [1:0] KIND_POINT = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // which product sequence the shared multiplier is running
    typedef enum logic [1:0] {
        MODE_MOTION,
        MODE_VIEW,
        MODE_PROJ
    } mode_t;

    typedef struct packed {
        logic       take;      // input word accepted this cycle
        logic       mul_en;    // issue one product
        mode_t      mode;
        logic [3:0] step;      // product number within the sequence
        logic       ins_init;  // latch insert position from kept count
        logic       ins_read;  // read entry just above insert position
        logic       ins_shift; // move that entry down one slot
        logic       ins_place; // write the new key, bump kept count
        logic       rd_out;    // load the output word from the read data
    } pcds_cmd_t;

    typedef struct packed {
        logic drop;      // point would overflow the frame
        logic dyn;       // motion term enabled
        logic clip_pass; // clip-space test passed
        logic pos_zero;  // insert position at the head
        logic rd_less;   // entry above is nearer than the new key
    } pcds_status_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sh0000_0000_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// File: hdl/point_cull_depth_sorter.sv
// Top level of the point cull and depth sort block.
//
//  channel   dir  bus            contents
//  s_*       in   tdata[228:0]   coef, point or read word; tuser = kind, tlast = last point
//  m_*       out  tdata[24:0]    sorted index and survivor count; tuser = has entry
//  p*        in   APB            reg 0 motion_time @0x0, reg 1 dynamic_enable @0x4
//
// Coefficient words are written to the table on acceptance; read words do one memory read,
// then load the output word. For a point, one shared 32x32 multiplier runs 3 + 16 + 16
// products (the 3 only with the motion term), then a drain and a clip-test state. A survivor
// then walks the sorted key memory upward, reading and shifting each displaced entry, then
// placing the new key.
// Reset clears coefficients, counters and control; the key memory needs no clearing.
// Input is only taken between words and while the output register is free or draining.
module point_cull_depth_sorter import pcds_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // coef_index, coef_value, mean_x, mean_y, mean_z, vel_x, vel_y, vel_z, pad
    input  logic [231:0] s_tdata,
    // kind
    input  logic [1:0]   s_tuser,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // sorted_index, survivor_count, pad
    output logic [31:0]  m_tdata,
    // has_entry
    output logic [0:0]   m_tuser,
    output logic         m_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    pcds_cmd_t          cmd;
    pcds_status_t       status;
    logic signed [31:0] motion_time_reg;
    logic               dynamic_enable_reg;
    logic               cfg_wr;
    logic [OUT_IDX_W-1:0] sorted_index;
    logic [OUT_CNT_W-1:0] survivor_count;
    logic               has_entry;

    // config registers; address bit 2 picks the register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = paddr[2] ? {31'd0, dynamic_enable_reg} : motion_time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motion_time_reg    <= '0;
            dynamic_enable_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2])
                dynamic_enable_reg <= pwdata[0];
            else
                motion_time_reg <= pwdata;
        end
    end

    pcds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_kind   (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pcds_dp #(
        .MAX_POINTS (MAX_POINTS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .kind           (s_tuser),
        .coef_index     (s_tdata[4:0]),
        .coef_value     (s_tdata[36:5]),
        .mean_x         (s_tdata[68:37]),
        .mean_y         (s_tdata[100:69]),
        .mean_z         (s_tdata[132:101]),
        .vel_x          (s_tdata[164:133]),
        .vel_y          (s_tdata[196:165]),
        .vel_z          (s_tdata[228:197]),
        .last_point     (s_tlast),
        .motion_time    (motion_time_reg),
        .dynamic_enable (dynamic_enable_reg),
        .sorted_index   (sorted_index),
        .has_entry      (has_entry),
        .last_entry     (m_tlast),
        .survivor_count (survivor_count)
    );

    assign m_tdata = {7'd0, survivor_count, sorted_index};
    assign m_tuser = has_entry;

endmodule

// File: hdl/pcds_ctrl.sv
// Sequencer for the point cull / depth sort datapath.
`include "point_cull_depth_sorter_assert.svh"

module pcds_ctrl import pcds_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [1:0]   s_kind,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  pcds_status_t status,
    output pcds_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOTION,
        ST_VIEW,
        ST_PROJ,
        ST_DRAIN,
        ST_TEST,
        ST_INS_CHK,
        ST_INS_CMP,
        ST_RD_WAIT
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       take;

    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign take     = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        cmd.take      = take;
        cmd.step      = step_reg;
        cmd.mode      = MODE_VIEW;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    step_next = '0;
                    case (s_kind)
                        KIND_POINT:
                        begin
                            if (!status.drop)
                                state_next = status.dyn ? ST_MOTION : ST_VIEW;
                        end
                        KIND_READ:  state_next = ST_RD_WAIT;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MOTION:
            begin
                cmd.mul_en = 1'b1;
                cmd.mode   = MODE_MOTION;
                step_next  = step_reg + 4'd1;
                if (step_reg == 4'd2)
                begin
                    step_next  = '0;
                    state_next = ST_VIEW;
                end
            end
            ST_VIEW:
            begin
                cmd.mul_en = 1'b1;
                cmd.mode   = MODE_VIEW;
                step_next  = step_reg + 4'd1;
                if (step_reg == 4'd15)
                    state_next = ST_PROJ;
            end
            ST_PROJ:
            begin
                cmd.mul_en = 1'b1;
                cmd.mode   = MODE_PROJ;
                step_next  = step_reg + 4'd1;
                if (step_reg == 4'd15)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
                state_next = ST_TEST;
            ST_TEST:
            begin
                cmd.ins_init = 1'b1;
                state_next   = status.clip_pass ? ST_INS_CHK : ST_IDLE;
            end
            ST_INS_CHK:
            begin
                if (status.pos_zero)
                begin
                    cmd.ins_place = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    cmd.ins_read = 1'b1;
                    state_next   = ST_INS_CMP;
                end
            end
            ST_INS_CMP:
            begin
                if (status.rd_less)
                begin
                    cmd.ins_shift = 1'b1;
                    state_next    = ST_INS_CHK;
                end
                else
                begin
                    cmd.ins_place = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_RD_WAIT:
            begin
                cmd.rd_out    = 1'b1;
                m_tvalid_next = 1'b1;
                state_next    = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    `PCDS_ASSERT_IMPLY(a_rd_slot_free, clk, rst_n, state_reg == ST_RD_WAIT, !m_tvalid_reg, "read result would overwrite a pending word")
    `PCDS_ASSERT_NEXT(a_read_waits, clk, rst_n, take && s_kind == KIND_READ, state_reg == ST_RD_WAIT, "read word did not start a memory read")
    `PCDS_ASSERT_NEXT(a_proj_drains, clk, rst_n, state_reg == ST_PROJ && step_reg == 4'd15, state_reg == ST_DRAIN, "projection did not drain")
    `PCDS_ASSERT_IMPLY(a_ins_onehot, clk, rst_n, 1'b1, $onehot0({cmd.ins_read, cmd.ins_shift, cmd.ins_place}), "conflicting insert commands")

endmodule

// File: hdl/pcds_dp.sv
// Datapath: matrix transform, clip test, depth key memory and counters.
module pcds_dp import pcds_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  pcds_cmd_t               cmd,
    output pcds_status_t            status,
    input  logic [1:0]              kind,
    input  logic [4:0]              coef_index,
    input  logic signed [31:0]      coef_value,
    input  logic signed [31:0]      mean_x,
    input  logic signed [31:0]      mean_y,
    input  logic signed [31:0]      mean_z,
    input  logic signed [31:0]      vel_x,
    input  logic signed [31:0]      vel_y,
    input  logic signed [31:0]      vel_z,
    input  logic                    last_point,
    input  logic signed [31:0]      motion_time,
    input  logic                    dynamic_enable,
    output logic [OUT_IDX_W-1:0]    sorted_index,
    output logic                    has_entry,
    output logic                    last_entry,
    output logic [OUT_CNT_W-1:0]    survivor_count
);

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int ENT_W = COEF_W + AW;
    localparam logic signed [31:0] ONE  = 32'(1 << FRAC_BITS);
    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

    logic signed [31:0] coef_reg [32];
    logic signed [31:0] mean_reg [3];
    logic signed [31:0] vel_reg  [3];
    logic signed [31:0] cam_reg  [4];
    logic signed [31:0] clip_reg [4];
    logic signed [31:0] pos4     [4];
    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic               d1_valid_reg;
    mode_t              d1_mode_reg;
    logic [3:0]         d1_step_reg;

    logic [CW-1:0]      pc_reg, pc_next, pc_eff;
    logic [CW-1:0]      kept_reg, kept_next, kept_eff;
    logic [CW-1:0]      rp_reg, rp_next, rp_eff;
    logic               closed_reg, closed_next;
    logic [CW-1:0]      pos_reg;
    logic [AW-1:0]      index_reg;
    logic signed [31:0] depth_reg;

    logic [ENT_W-1:0]   mem [MAX_POINTS];
    logic [ENT_W-1:0]   rd_data_reg;
    logic [AW-1:0]      rd_addr;
    logic               rd_avail;
    logic [31:0]        idx32, cnt32;

    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] rnd, acc_sum, mot_sum;
    logic signed [35:0] lim, lhs [3];
    logic [2:0]         in_box;

    // operand select for the shared multiplier
    always_comb
    begin
        pos4[0] = mean_reg[0];
        pos4[1] = mean_reg[1];
        pos4[2] = mean_reg[2];
        pos4[3] = ONE;
        mul_a   = '0;
        mul_b   = '0;
        case (cmd.mode)
            MODE_MOTION:
            begin
                case (cmd.step[1:0])
                    2'd0:    mul_a = vel_reg[0];
                    2'd1:    mul_a = vel_reg[1];
                    default: mul_a = vel_reg[2];
                endcase
                mul_b = motion_time;
            end
            MODE_VIEW:
            begin
                mul_a = coef_reg[{1'b0, cmd.step}];
                mul_b = pos4[cmd.step[1:0]];
            end
            MODE_PROJ:
            begin
                mul_a = coef_reg[{1'b1, cmd.step}];
                mul_b = cam_reg[cmd.step[1:0]];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // rounded product, row sum, motion update
    always_comb
    begin
        rnd     = (prod_reg + HALF) >>> FRAC_BITS;
        acc_sum = ((d1_step_reg[1:0] == 2'd0) ? 64'sd0 : acc_reg) + rnd;
        case (d1_step_reg[1:0])
            2'd0:    mot_sum = 64'(mean_reg[0]) + 64'(sat32(rnd));
            2'd1:    mot_sum = 64'(mean_reg[1]) + 64'(sat32(rnd));
            default: mot_sum = 64'(mean_reg[2]) + 64'(sat32(rnd));
        endcase
    end

    // clip box: -6w <= 5c <= 6w
    always_comb
    begin
        lim = (36'(clip_reg[3]) <<< 2) + (36'(clip_reg[3]) <<< 1);
        for (int i = 0; i < 3; i++)
        begin
            lhs[i]    = (36'(clip_reg[i]) <<< 2) + 36'(clip_reg[i]);
            in_box[i] = (lhs[i] <= lim) && (lhs[i] >= -lim);
        end
    end

    // frame bookkeeping
    always_comb
    begin
        pc_eff      = closed_reg ? '0 : pc_reg;
        kept_eff    = closed_reg ? '0 : kept_reg;
        rp_eff      = closed_reg ? '0 : rp_reg;
        pc_next     = pc_reg;
        kept_next   = kept_reg;
        rp_next     = rp_reg;
        closed_next = closed_reg;
        rd_avail    = closed_reg && (rp_reg < kept_reg);
        if (cmd.take && kind == KIND_POINT)
        begin
            closed_next = last_point;
            kept_next   = kept_eff;
            rp_next     = rp_eff;
            pc_next     = status.drop ? pc_eff : pc_eff + CW'(1);
        end
        if (cmd.ins_place)
            kept_next = kept_reg + CW'(1);
        if (cmd.rd_out && rd_avail)
            rp_next = rp_reg + CW'(1);
    end

    assign rd_addr = cmd.ins_read ? AW'(pos_reg - CW'(1)) : rp_reg[AW-1:0];

    assign status.drop      = pc_eff >= CW'(MAX_POINTS);
    assign status.dyn       = dynamic_enable;
    assign status.clip_pass = &in_box;
    assign status.pos_zero  = (pos_reg == '0);
    assign status.rd_less   = $signed(rd_data_reg[ENT_W-1:AW]) < depth_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 32; i++)
                coef_reg[i] <= '0;
            pc_reg       <= '0;
            kept_reg     <= '0;
            rp_reg       <= '0;
            closed_reg   <= 1'b0;
            d1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.take && kind == KIND_COEF)
                coef_reg[coef_index] <= coef_value;
            pc_reg       <= pc_next;
            kept_reg     <= kept_next;
            rp_reg       <= rp_next;
            closed_reg   <= closed_next;
            d1_valid_reg <= cmd.mul_en;
        end
    end

    always_ff @(posedge clk)
    begin
        d1_mode_reg <= cmd.mode;
        d1_step_reg <= cmd.step;
        if (cmd.mul_en)
            prod_reg <= mul_a * mul_b;
        if (cmd.take && kind == KIND_POINT)
        begin
            mean_reg[0] <= mean_x;
            mean_reg[1] <= mean_y;
            mean_reg[2] <= mean_z;
            vel_reg[0]  <= vel_x;
            vel_reg[1]  <= vel_y;
            vel_reg[2]  <= vel_z;
            index_reg   <= pc_eff[AW-1:0];
        end
        if (d1_valid_reg)
        begin
            case (d1_mode_reg)
                MODE_MOTION:
                begin
                    case (d1_step_reg[1:0])
                        2'd0:    mean_reg[0] <= sat32(mot_sum);
                        2'd1:    mean_reg[1] <= sat32(mot_sum);
                        default: mean_reg[2] <= sat32(mot_sum);
                    endcase
                end
                MODE_VIEW:
                begin
                    acc_reg <= acc_sum;
                    if (d1_step_reg[1:0] == 2'd3)
                        cam_reg[d1_step_reg[3:2]] <= sat32(acc_sum);
                end
                MODE_PROJ:
                begin
                    acc_reg <= acc_sum;
                    if (d1_step_reg[1:0] == 2'd3)
                        clip_reg[d1_step_reg[3:2]] <= sat32(acc_sum);
                end
                default:
                    acc_reg <= acc_sum;
            endcase
        end
        if (cmd.ins_init)
        begin
            pos_reg   <= kept_reg;
            depth_reg <= cam_reg[2];
        end
        if (cmd.ins_shift)
            pos_reg <= pos_reg - CW'(1);
    end

    // depth key memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.ins_shift)
            mem[pos_reg[AW-1:0]] <= rd_data_reg;
        else if (cmd.ins_place)
            mem[pos_reg[AW-1:0]] <= {depth_reg, index_reg};
        rd_data_reg <= mem[rd_addr];
    end

    assign idx32 = 32'(rd_data_reg[AW-1:0]);
    assign cnt32 = 32'(kept_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.rd_out)
        begin
            survivor_count <= cnt32[OUT_CNT_W-1:0];
            sorted_index   <= rd_avail ? idx32[OUT_IDX_W-1:0] : '0;
            has_entry      <= rd_avail;
            last_entry     <= rd_avail && (rp_reg + CW'(1) == kept_reg);
        end
    end

endmodule
